// File: hdl/tbs_pkg.sv
// shared types and token constants for the token byte stuffer
`default_nettype none

package tbs_pkg;

	localparam int FLAG_LEN  = 5;
	localparam int ESC_LEN   = 4;
	localparam int WIN_DEPTH = 4;
	localparam int WIN_MAX   = WIN_DEPTH + 1;

	localparam logic [7:0] FLAG_TOK [FLAG_LEN] = '{8'h66, 8'h6C, 8'h61, 8'h67, 8'h20};
	localparam logic [7:0] ESC_TOK  [ESC_LEN]  = '{8'h65, 8'h73, 8'h63, 8'h20};

	// everything one input beat has to emit
	typedef struct packed {
		logic                        open;
		logic                        close;
		logic [2:0]                  nbyte;
		logic [WIN_MAX-1:0]          esc;
		logic [WIN_MAX-1:0][7:0]     bytes;
	} job_t;

endpackage

`default_nettype wire

// File: hdl/token_byte_stuffer.sv
// top level of the token byte stuffer: framing and escaping of a byte stream
//
// Frames a message that arrives one byte per input beat, frame_end on the last
// beat. The first beat of a frame sends the opening token "flag ", every data
// byte at which a whole "flag " or "esc " token starts is preceded by an
// inserted "esc ", and the closing beat flushes the four-byte look-ahead window
// (matching only tokens that still fit) and ends with "flag ", whose last byte
// carries frame_done. A beat with has_byte low and frame_end high closes the
// frame (or sends an empty frame); a beat with both low is taken and dropped.
// Rate: one output byte per cycle while out_ready does not stall the output; a
// beat yielding zero or one byte is then taken every cycle, one yielding more (up
// to 14) holds the input until its last byte is out, set by the single output byte
// lane. An accepted beat passes the job register, then the output register, before
// its first output byte. run_last marks the last output byte of each input beat.
`default_nettype none

module token_byte_stuffer
	import tbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	// input beats
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_byte,
	input  wire logic       frame_end,

	// stuffed byte stream
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_done
);

	job_t job;
	logic job_valid;
	logic load_ok;
	logic accept;

	// a new beat is taken when the sequencer is idle or is sending the last byte of its job
	assign in_ready = load_ok;
	assign accept   = in_valid && in_ready;

	// window update and escape decisions happen at acceptance
	tbs_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.frame_end (frame_end),
		.job       (job),
		.job_valid (job_valid)
	);

	// beats that emit nothing never reach the sequencer
	tbs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept && job_valid),
		.job        (job),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

endmodule

`default_nettype wire

// File: hdl/tbs_window.sv
// look-ahead window, frame state and escape decisions for one input beat
`default_nettype none

module tbs_window
	import tbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_byte,
	input  wire logic       frame_end,
	output job_t            job,
	output logic            job_valid
);

	logic [7:0] pend_q [WIN_DEPTH];
	logic [2:0] count_q;
	logic       in_frame_q;

	logic [7:0] win     [WIN_MAX];
	logic [7:0] win_ext [WIN_MAX + FLAG_LEN - 1];
	logic [2:0] n_eff;
	logic [2:0] n;
	logic [2:0] ndec;

	always_comb begin
		logic flag_m;
		logic esc_m;
		n_eff = in_frame_q ? count_q : 3'd0;
		n     = n_eff + {2'b00, has_byte};
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win[i] = (3'(i) < n_eff) ? pend_q[i] : data_byte;
		end
		win[WIN_DEPTH] = data_byte;
		for (int i = 0; i < WIN_MAX + FLAG_LEN - 1; i++) begin
			win_ext[i] = (i < WIN_MAX) ? win[(i < WIN_MAX) ? i : 0] : 8'h00;
		end
		if (frame_end) begin
			ndec = n;
		end else begin
			ndec = (n == 3'(WIN_MAX)) ? 3'd1 : 3'd0;
		end
		job.open  = !in_frame_q;
		job.close = frame_end;
		job.nbyte = ndec;
		for (int i = 0; i < WIN_MAX; i++) begin
			// a token counts only if all its bytes are in the window
			flag_m = ((4'(i) + 4'(FLAG_LEN)) <= {1'b0, n});
			esc_m  = ((4'(i) + 4'(ESC_LEN)) <= {1'b0, n});
			for (int t = 0; t < FLAG_LEN; t++) begin
				if (win_ext[i + t] != FLAG_TOK[t]) begin
					flag_m = 1'b0;
				end
			end
			for (int t = 0; t < ESC_LEN; t++) begin
				if (win_ext[i + t] != ESC_TOK[t]) begin
					esc_m = 1'b0;
				end
			end
			job.esc[i]   = flag_m | esc_m;
			job.bytes[i] = win[i];
		end
		job_valid = (has_byte | frame_end) && (!in_frame_q || ndec != 3'd0 || frame_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= 3'd0;
			in_frame_q <= 1'b0;
		end else if (accept && (has_byte || frame_end)) begin
			if (frame_end) begin
				count_q    <= 3'd0;
				in_frame_q <= 1'b0;
			end else begin
				count_q    <= n - ndec;
				in_frame_q <= 1'b1;
			end
		end
	end

	// without frame_end at most the oldest byte leaves the window
	always_ff @(posedge clk) begin
		if (accept && has_byte && !frame_end) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				pend_q[i] <= ndec[0] ? win[i + 1] : win[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/tbs_emit.sv
// sequencer that walks one job out as a byte stream through an output register
`default_nettype none

module tbs_emit
	import tbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  job_t            job,
	output logic            load_ok,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_done
);

	typedef enum logic [3:0] {
		PH_OPEN  = 4'b0001,
		PH_ESC   = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_CLOSE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic   more;
		phase_t ph;
	} entry_t;

	// where the stream goes once bytes before idx are out
	function automatic entry_t entry_at(job_t j, logic [2:0] idx);
		entry_t e;
		if (idx < j.nbyte) begin
			e.more = 1'b1;
			e.ph   = j.esc[idx] ? PH_ESC : PH_DATA;
		end else begin
			e.more = j.close;
			e.ph   = PH_CLOSE;
		end
		return e;
	endfunction

	job_t       job_s1;
	logic       job_valid_s1;
	phase_t     phase_q;
	logic [2:0] tok_q;
	logic [2:0] bi_q;

	logic       advance;
	logic [7:0] step_byte;
	logic       step_last;
	logic       step_done;
	phase_t     nxt_phase;
	logic [2:0] nxt_tok;
	logic [2:0] nxt_bi;
	entry_t     ent_next;
	entry_t     ent_load;

	assign advance  = job_valid_s1 && (!out_valid || out_ready);
	assign load_ok  = !job_valid_s1 || (advance && step_last);
	assign ent_load = entry_at(job, 3'd0);

	always_comb begin
		step_byte = 8'h00;
		step_last = 1'b0;
		step_done = 1'b0;
		nxt_phase = phase_q;
		nxt_tok   = tok_q + 3'd1;
		nxt_bi    = bi_q;
		ent_next  = entry_at(job_s1, bi_q + 3'd1);
		unique case (phase_q)
			PH_OPEN: begin
				step_byte = FLAG_TOK[tok_q];
				if (tok_q == 3'(FLAG_LEN - 1)) begin
					ent_next  = entry_at(job_s1, 3'd0);
					nxt_phase = ent_next.ph;
					nxt_tok   = 3'd0;
					step_last = !ent_next.more;
				end
			end
			PH_ESC: begin
				step_byte = ESC_TOK[tok_q[1:0]];
				if (tok_q == 3'(ESC_LEN - 1)) begin
					nxt_phase = PH_DATA;
					nxt_tok   = 3'd0;
				end
			end
			PH_DATA: begin
				step_byte = job_s1.bytes[bi_q];
				nxt_phase = ent_next.ph;
				nxt_tok   = 3'd0;
				nxt_bi    = bi_q + 3'd1;
				step_last = !ent_next.more;
			end
			PH_CLOSE: begin
				step_byte = FLAG_TOK[tok_q];
				step_last = (tok_q == 3'(FLAG_LEN - 1));
				step_done = step_last;
			end
			default: begin
				step_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			phase_q      <= PH_OPEN;
			tok_q        <= 3'd0;
			bi_q         <= 3'd0;
			out_valid    <= 1'b0;
		end else begin
			if (load) begin
				job_valid_s1 <= 1'b1;
				phase_q      <= job.open ? PH_OPEN : ent_load.ph;
				tok_q        <= 3'd0;
				bi_q         <= 3'd0;
			end else if (advance) begin
				job_valid_s1 <= !step_last;
				phase_q      <= nxt_phase;
				tok_q        <= nxt_tok;
				bi_q         <= nxt_bi;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
		end
		if (advance) begin
			out_byte   <= step_byte;
			run_last   <= step_last;
			frame_done <= step_done;
		end
	end

endmodule

`default_nettype wire
